[rtl/core/msched_pkg.sv]
// Shared types and constants for the multilevel queue scheduler.
package msched_pkg;

  localparam int TIME_W  = 32;
  localparam int BURST_W = 16;
  localparam int IDP_W   = 4;
  localparam int QUANT_W = 8;

  localparam logic [QUANT_W-1:0] QUANT_RESET = 8'd2;

  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  localparam logic LVL_RR   = 1'b0;
  localparam logic LVL_FCFS = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic arrive;
    logic tick_begin;
    logic rd_task;
    logic rd_head;
    logic idle_tick;
    logic pop;
    logic run;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_active;
    logic rr_nonempty;
    logic fcfs_nonempty;
    logic out_free;
  } dp_stat_t;

  // Per-task entry written once at arrival.
  typedef struct packed {
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
  } task_info_t;

  // Per-task entry updated as the task runs.
  typedef struct packed {
    logic [BURST_W-1:0] remaining;
    logic               started;
    logic [TIME_W-1:0]  first_run;
  } task_run_t;

endpackage

[rtl/core/multilevel_queue_scheduler.sv]
// Top level of the two-level (round-robin over first-come) task scheduler.
//
// Usage: requests enter on the in_ channel (valid/ready). An arrival request
// (in_action = 0) registers a task id with its burst and level and appends it
// to the round-robin or the first-come queue; it produces no result. A tick
// request (in_action = 1) advances time by one unit and produces exactly one
// result request on the out_ channel describing what ran during that unit.
// The quantum register is written through cfg_we/cfg_wdata while idle.
//
// Timing: arrivals stream at one per cycle while no tick is in progress.
// A tick goes from acceptance to a select state, then for a new slot to a
// pop state after the registered queue head read, to a run state after the
// registered task table read and to an output state; an open slot skips
// the pop state, and with nothing to run a tick goes straight to output.
// The result is loaded into the output register in the output state and
// shows on out_valid in the next cycle. The output register decouples the
// channels: arrivals are still accepted while a result waits, and a tick
// only holds in its output state if the previous result is not yet taken.
// Reset (rst_n low, synchronous) empties both queues, clears all active
// tasks, sets time to zero and the quantum to 2; there is no clearing pass.
module multilevel_queue_scheduler import msched_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [QUANT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [IDP_W-1:0]   in_task_id,
  input  logic               in_queue_level,
  input  logic [BURST_W-1:0] in_burst_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_idle,
  output logic [IDP_W-1:0]   out_running_id,
  output logic               out_slot_start,
  output logic               out_finished,
  output logic [TIME_W-1:0]  out_completion_time,
  output logic [TIME_W-1:0]  out_turnaround,
  output logic [TIME_W-1:0]  out_waiting,
  output logic [TIME_W-1:0]  out_response
);

  // The controller issues one command per cycle; the datapath reports back
  // slot and queue occupancy and whether the result register can be loaded.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  msched_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_valid),
    .in_action_i (in_action),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready)
  );

  // The datapath holds the time base, the per-task tables, both queues and
  // the result register that feeds the out_ channel.
  msched_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .cfg_we_i              (cfg_we),
    .cfg_wdata_i           (cfg_wdata),
    .in_task_id_i          (in_task_id),
    .in_queue_level_i      (in_queue_level),
    .in_burst_length_i     (in_burst_length),
    .out_ready_i           (out_ready),
    .out_valid_o           (out_valid),
    .out_idle_o            (out_idle),
    .out_running_id_o      (out_running_id),
    .out_slot_start_o      (out_slot_start),
    .out_finished_o        (out_finished),
    .out_completion_time_o (out_completion_time),
    .out_turnaround_o      (out_turnaround),
    .out_waiting_o         (out_waiting),
    .out_response_o        (out_response)
  );

endmodule

[rtl/core/msched_fifo.sv]
// Task id FIFO with a registered head read.
module msched_fifo import msched_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  input  logic              rd_i,
  output logic [DATA_W-1:0] head_o,
  output logic              nonempty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] head_q;
  logic [PTR_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push_ok, pop_ok;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ok = push_i && (count_r != CNT_W'(DEPTH));
  assign pop_ok  = pop_i && (count_r != '0);

  always_comb begin
    head_nxt  = pop_ok ? ptr_inc(head_r) : head_r;
    tail_nxt  = push_ok ? ptr_inc(tail_r) : tail_r;
    count_nxt = count_r + CNT_W'(push_ok) - CNT_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail_r] <= push_data_i;
    end
    if (rd_i) begin
      head_q <= mem[head_r];
    end
  end

  assign head_o     = head_q;
  assign nonempty_o = (count_r != '0);

endmodule

[rtl/core/msched_dp.sv]
// Scheduler datapath: task tables, queues, time base and result register.
module msched_dp import msched_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  input  logic               cfg_we_i,
  input  logic [QUANT_W-1:0] cfg_wdata_i,
  input  logic [IDP_W-1:0]   in_task_id_i,
  input  logic               in_queue_level_i,
  input  logic [BURST_W-1:0] in_burst_length_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               out_idle_o,
  output logic [IDP_W-1:0]   out_running_id_o,
  output logic               out_slot_start_o,
  output logic               out_finished_o,
  output logic [TIME_W-1:0]  out_completion_time_o,
  output logic [TIME_W-1:0]  out_turnaround_o,
  output logic [TIME_W-1:0]  out_waiting_o,
  output logic [TIME_W-1:0]  out_response_o
);

  localparam int ID_W = $clog2(MAX_TASKS);

  task_info_t info_mem [MAX_TASKS];
  task_run_t  run_mem  [MAX_TASKS];
  task_info_t info_q;
  task_run_t  run_q;

  logic [MAX_TASKS-1:0] active_r;
  logic [QUANT_W-1:0]   quantum_r;
  logic [TIME_W-1:0]    now_r;
  logic [ID_W-1:0]      cur_r;
  logic                 cur_level_r;
  logic                 slot_active_r;
  logic [BURST_W-1:0]   slot_left_r;
  logic                 requeue_r;
  logic                 slot_start_r;
  logic                 res_idle_r;
  logic                 res_fin_r;
  logic [TIME_W-1:0]    comp_r, tat_r, resp_r;
  logic [BURST_W-1:0]   burst_r;
  logic                 out_valid_r;

  logic [ID_W-1:0]      arr_idx;
  logic                 arrive_ok;
  logic                 requeue_push;
  logic                 rr_push, fcfs_push;
  logic [ID_W-1:0]      push_id;
  logic [ID_W-1:0]      rr_head, fcfs_head, pop_id;
  logic                 rr_ne, fcfs_ne;
  logic                 rd_en;
  logic [ID_W-1:0]      rd_addr;
  logic                 run_we;
  logic [ID_W-1:0]      run_waddr;
  task_run_t            run_wdata;

  logic [QUANT_W-1:0]   q_eff;
  logic [BURST_W-1:0]   q_ext, sl_open, sl_cur, sl_nxt, rem_nxt;
  logic [TIME_W-1:0]    now_nxt, first_t;
  logic                 fin;

  // Arrival qualification: id inside the table, nonzero burst, not already active.
  assign arr_idx   = ID_W'(in_task_id_i);
  assign arrive_ok = cmd_i.arrive && (32'(in_task_id_i) < MAX_TASKS)
                     && (in_burst_length_i != '0) && !active_r[arr_idx];

  assign requeue_push = cmd_i.tick_begin && requeue_r;
  assign rr_push   = (arrive_ok && (in_queue_level_i == LVL_RR))
                     || (requeue_push && (cur_level_r == LVL_RR));
  assign fcfs_push = (arrive_ok && (in_queue_level_i == LVL_FCFS))
                     || (requeue_push && (cur_level_r == LVL_FCFS));
  assign push_id   = arrive_ok ? arr_idx : cur_r;

  msched_fifo #(.DEPTH(MAX_TASKS), .DATA_W(ID_W)) u_rr_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (rr_push),
    .push_data_i (push_id),
    .pop_i       (cmd_i.pop && rr_ne),
    .rd_i        (cmd_i.rd_head),
    .head_o      (rr_head),
    .nonempty_o  (rr_ne)
  );

  msched_fifo #(.DEPTH(MAX_TASKS), .DATA_W(ID_W)) u_fcfs_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (fcfs_push),
    .push_data_i (push_id),
    .pop_i       (cmd_i.pop && !rr_ne),
    .rd_i        (cmd_i.rd_head),
    .head_o      (fcfs_head),
    .nonempty_o  (fcfs_ne)
  );

  // The round-robin queue always wins over the first-come queue.
  assign pop_id  = rr_ne ? rr_head : fcfs_head;
  assign rd_en   = cmd_i.rd_task || cmd_i.pop;
  assign rd_addr = cmd_i.pop ? pop_id : cur_r;

  // One tick of execution on the current task.
  always_comb begin
    q_eff   = (quantum_r == '0) ? QUANT_W'(1) : quantum_r;
    q_ext   = BURST_W'(q_eff);
    sl_open = ((cur_level_r == LVL_FCFS) || (run_q.remaining < q_ext))
              ? run_q.remaining : q_ext;
    sl_cur  = slot_start_r ? sl_open : slot_left_r;
    sl_nxt  = sl_cur - 1'b1;
    rem_nxt = run_q.remaining - 1'b1;
    now_nxt = now_r + 1'b1;
    first_t = run_q.started ? run_q.first_run : now_r;
    fin     = (rem_nxt == '0);
  end

  always_comb begin
    run_we    = arrive_ok || cmd_i.run;
    run_waddr = cmd_i.run ? cur_r : arr_idx;
    if (cmd_i.run) begin
      run_wdata = '{remaining: rem_nxt, started: 1'b1, first_run: first_t};
    end else begin
      run_wdata = '{remaining: in_burst_length_i, started: 1'b0, first_run: now_r};
    end
  end

  always_ff @(posedge clk) begin
    if (arrive_ok) begin
      info_mem[arr_idx] <= '{arrival: now_r, burst: in_burst_length_i};
    end
    if (run_we) begin
      run_mem[run_waddr] <= run_wdata;
    end
    if (rd_en) begin
      info_q <= info_mem[rd_addr];
      run_q  <= run_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= '0;
      quantum_r     <= QUANT_RESET;
      now_r         <= '0;
      cur_r         <= '0;
      cur_level_r   <= LVL_RR;
      slot_active_r <= 1'b0;
      slot_left_r   <= '0;
      requeue_r     <= 1'b0;
      slot_start_r  <= 1'b0;
      res_idle_r    <= 1'b0;
      res_fin_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        quantum_r <= cfg_wdata_i;
      end
      if (arrive_ok) begin
        active_r[arr_idx] <= 1'b1;
      end
      if (cmd_i.tick_begin) begin
        requeue_r <= 1'b0;
      end
      if (cmd_i.rd_task) begin
        slot_start_r <= 1'b0;
      end
      if (cmd_i.idle_tick) begin
        now_r        <= now_nxt;
        res_idle_r   <= 1'b1;
        res_fin_r    <= 1'b0;
        slot_start_r <= 1'b0;
      end
      if (cmd_i.pop) begin
        cur_r         <= pop_id;
        cur_level_r   <= rr_ne ? LVL_RR : LVL_FCFS;
        slot_active_r <= 1'b1;
        slot_start_r  <= 1'b1;
      end
      if (cmd_i.run) begin
        now_r       <= now_nxt;
        slot_left_r <= sl_nxt;
        res_idle_r  <= 1'b0;
        res_fin_r   <= fin;
        if (fin) begin
          active_r[cur_r] <= 1'b0;
          slot_active_r   <= 1'b0;
        end else if (sl_nxt == '0) begin
          slot_active_r <= 1'b0;
          requeue_r     <= 1'b1;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.run) begin
      comp_r  <= now_nxt;
      tat_r   <= now_nxt - info_q.arrival;
      resp_r  <= first_t - info_q.arrival;
      burst_r <= info_q.burst;
    end
    if (cmd_i.load_out) begin
      out_idle_o            <= res_idle_r;
      out_running_id_o      <= res_idle_r ? '0 : IDP_W'(cur_r);
      out_slot_start_o      <= slot_start_r && !res_idle_r;
      out_finished_o        <= res_fin_r;
      out_completion_time_o <= res_fin_r ? comp_r : '0;
      out_turnaround_o      <= res_fin_r ? tat_r : '0;
      out_waiting_o         <= res_fin_r ? (tat_r - TIME_W'(burst_r)) : '0;
      out_response_o        <= res_fin_r ? resp_r : '0;
    end
  end

  assign out_valid_o          = out_valid_r;
  assign stat_o.slot_active   = slot_active_r;
  assign stat_o.rr_nonempty   = rr_ne;
  assign stat_o.fcfs_nonempty = fcfs_ne;
  assign stat_o.out_free      = !out_valid_r || out_ready_i;

`ifndef SYNTHESIS
  a_run_on_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.run |-> active_r[cur_r])
    else $error("execution step on a task that is not active");

  a_slot_xor_requeue: assert property (@(posedge clk) disable iff (!rst_n)
    !(slot_active_r && requeue_r))
    else $error("open slot while a requeue is still pending");

  a_slot_task_active: assert property (@(posedge clk) disable iff (!rst_n)
    slot_active_r |-> active_r[cur_r])
    else $error("open slot holds an inactive task");
`endif

endmodule

[rtl/core/msched_ctrl.sv]
// Scheduler controller: sequences arrivals and ticks through the datapath.
module msched_ctrl import msched_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid_i,
  input  logic     in_action_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     in_ready_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEL  = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd_o     = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == ACT_TICK) begin
            cmd_o.tick_begin = 1'b1;
            state_nxt        = S_SEL;
          end else begin
            cmd_o.arrive = 1'b1;
          end
        end
      end
      S_SEL: begin
        priority if (stat_i.slot_active) begin
          cmd_o.rd_task = 1'b1;
          state_nxt     = S_RUN;
        end else if (stat_i.rr_nonempty || stat_i.fcfs_nonempty) begin
          cmd_o.rd_head = 1'b1;
          state_nxt     = S_POP;
        end else begin
          cmd_o.idle_tick = 1'b1;
          state_nxt       = S_OUT;
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready_o = (state_r == S_IDLE);

`ifndef SYNTHESIS
  a_pop_after_select: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> ($past(state_r) == S_SEL))
    else $error("queue pop without a preceding head read");
`endif

endmodule

[bench/testbench.sv]
// Self-checking testbench for the two-level round-robin over first-come task scheduler.
module testbench;
  import msched_pkg::*;

  // One tick result as the block reports it on the out_ channel.
  typedef struct packed {
    logic               idle;
    logic [IDP_W-1:0]   running_id;
    logic               slot_start;
    logic               finished;
    logic [TIME_W-1:0]  completion_time;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  waiting;
    logic [TIME_W-1:0]  response;
  } tick_report_t;

  // One row of the directed table. Rows with typed set carry a result that is
  // obvious by inspection; all other rows are checked against the predictor.
  typedef struct packed {
    logic               act;
    logic [IDP_W-1:0]   id;
    logic               lvl;
    logic [BURST_W-1:0] burst;
    logic               typed;
    tick_report_t       want;
  } stim_row_t;

  localparam int NUM_TASKS    = 16;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 190;
  localparam int DIR_ROWS     = 23;

  localparam tick_report_t NO_REPORT   = '0;
  localparam tick_report_t IDLE_REPORT =
    '{1'b1, 4'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0};
  // Task 0 arrives at time 1 with a one-unit burst and runs at once, so it
  // completes at time 2 with no waiting and no response delay.
  localparam tick_report_t FIRST_DONE  =
    '{1'b0, 4'd0, 1'b1, 1'b1, 32'd2, 32'd1, 32'd0, 32'd0};

  // The directed table starts from reset with the default quantum of 2.
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{ACT_TICK,   4'd0,  LVL_RR,   16'd0,      1'b1, IDLE_REPORT},  // nothing queued
    '{ACT_ARRIVE, 4'd0,  LVL_RR,   16'd1,      1'b0, NO_REPORT},
    '{ACT_TICK,   4'd0,  LVL_RR,   16'd0,      1'b1, FIRST_DONE},
    '{ACT_ARRIVE, 4'd15, LVL_FCFS, 16'd0,      1'b0, NO_REPORT},    // zero burst, dropped
    '{ACT_TICK,   4'd15, LVL_FCFS, 16'hFFFF,   1'b1, IDLE_REPORT},
    '{ACT_ARRIVE, 4'd3,  LVL_FCFS, 16'd3,      1'b0, NO_REPORT},
    '{ACT_ARRIVE, 4'd3,  LVL_RR,   16'hFFFF,   1'b0, NO_REPORT},    // duplicate, dropped
    '{ACT_ARRIVE, 4'd5,  LVL_RR,   16'd5,      1'b0, NO_REPORT},
    '{ACT_TICK,   4'd0,  LVL_RR,   16'd0,      1'b0, NO_REPORT},    // round-robin wins
    '{ACT_TICK,   4'd0,  LVL_RR,   16'd0,      1'b0, NO_REPORT},    // quantum expires
    '{ACT_ARRIVE, 4'd7,  LVL_RR,   16'd2,      1'b0, NO_REPORT},    // arrives at slot end
    '{ACT_ARRIVE, 4'd5,  LVL_RR,   16'd1,      1'b0, NO_REPORT},    // awaiting requeue
    '{ACT_TICK,   4'd0,  LVL_RR,   16'd0,      1'b0, NO_REPORT},    // task 7 goes first
    '{ACT_TICK,   4'd0,  LVL_RR,   16'd0,      1'b0, NO_REPORT},
    '{ACT_TICK,   4'd0,  LVL_RR,   16'd0,      1'b0, NO_REPORT},
    '{ACT_TICK,   4'd0,  LVL_RR,   16'd0,      1'b0, NO_REPORT},
    '{ACT_TICK,   4'd0,  LVL_RR,   16'd0,      1'b0, NO_REPORT},
    '{ACT_TICK,   4'd0,  LVL_RR,   16'd0,      1'b0, NO_REPORT},    // first-come starts
    '{ACT_ARRIVE, 4'd9,  LVL_RR,   16'd1,      1'b0, NO_REPORT},    // no preemption
    '{ACT_TICK,   4'd0,  LVL_RR,   16'd0,      1'b0, NO_REPORT},
    '{ACT_TICK,   4'd0,  LVL_RR,   16'd0,      1'b0, NO_REPORT},
    '{ACT_TICK,   4'd0,  LVL_RR,   16'd0,      1'b0, NO_REPORT},
    '{ACT_TICK,   4'd0,  LVL_RR,   16'd0,      1'b0, IDLE_REPORT}
  };

  logic               clk;
  logic               rst_n           = 1'b0;
  logic               cfg_we          = 1'b0;
  logic [QUANT_W-1:0] cfg_wdata       = '0;
  logic               in_valid        = 1'b0;
  logic               in_ready;
  logic               in_action       = ACT_ARRIVE;
  logic [IDP_W-1:0]   in_task_id      = '0;
  logic               in_queue_level  = LVL_RR;
  logic [BURST_W-1:0] in_burst_length = '0;
  logic               out_valid;
  logic               out_ready       = 1'b0;
  logic               out_idle;
  logic [IDP_W-1:0]   out_running_id;
  logic               out_slot_start;
  logic               out_finished;
  logic [TIME_W-1:0]  out_completion_time;
  logic [TIME_W-1:0]  out_turnaround;
  logic [TIME_W-1:0]  out_waiting;
  logic [TIME_W-1:0]  out_response;

  multilevel_queue_scheduler #(.MAX_TASKS(NUM_TASKS)) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_task_id          (in_task_id),
    .in_queue_level      (in_queue_level),
    .in_burst_length     (in_burst_length),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_idle            (out_idle),
    .out_running_id      (out_running_id),
    .out_slot_start      (out_slot_start),
    .out_finished        (out_finished),
    .out_completion_time (out_completion_time),
    .out_turnaround      (out_turnaround),
    .out_waiting         (out_waiting),
    .out_response        (out_response)
  );

  // Scheduler shadow state. The per-task tables are only read for tasks
  // that an arrival has registered, exactly as in the block.
  logic [TIME_W-1:0]  sched_now = '0;
  logic [TIME_W-1:0]  arrived_at  [NUM_TASKS];
  logic [BURST_W-1:0] burst_of    [NUM_TASKS];
  logic [BURST_W-1:0] units_left  [NUM_TASKS];
  logic               level_of    [NUM_TASKS];
  logic [TIME_W-1:0]  first_start [NUM_TASKS];
  bit                 started     [NUM_TASKS];
  bit                 busy        [NUM_TASKS];
  logic [IDP_W-1:0]   rr_line[$];
  logic [IDP_W-1:0]   fcfs_line[$];
  logic [IDP_W-1:0]   cur_id      = '0;
  bit                 slot_open   = 1'b0;
  logic [BURST_W-1:0] slot_units  = '0;
  bit                 requeue_due = 1'b0;
  logic [QUANT_W-1:0] quantum     = QUANT_RESET;

  // Results predicted for accepted tick requests, oldest first.
  tick_report_t tick_reports[$];

  int mismatch_count = 0;
  bit gaps_on        = 1'b1;  // sender leaves random gaps between requests
  bit rx_stalls_on   = 1'b1;  // receiver drops out_ready in random bursts
  bit hold_request   = 1'b0;  // asks the receiver for one long hold-off
  int stall_left     = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Appends a task to the queue of its level.
  task automatic push_line(input logic [IDP_W-1:0] id);
    if (level_of[id] == LVL_RR) begin
      rr_line = {rr_line, id};
    end else begin
      fcfs_line = {fcfs_line, id};
    end
  endtask

  // Advances the shadow scheduler by one accepted request. A tick always
  // yields one expected result; an arrival never does.
  task automatic schedule_request(input logic act, input logic [IDP_W-1:0] id,
                                  input logic lvl, input logic [BURST_W-1:0] burst);
    tick_report_t       rep;
    logic [BURST_W-1:0] q;
    if (act == ACT_ARRIVE) begin
      // Arrivals with no work or for a task that is still queued, running
      // or waiting for its requeue are dropped silently.
      if (burst == '0 || busy[id]) return;
      busy[id]        = 1'b1;
      arrived_at[id]  = sched_now;
      burst_of[id]    = burst;
      units_left[id]  = burst;
      level_of[id]    = lvl;
      started[id]     = 1'b0;
      push_line(id);
      return;
    end
    rep = '0;
    // A preempted round-robin task rejoins its queue only now, behind any
    // arrivals that landed exactly at the end of its slot.
    if (requeue_due) begin
      push_line(cur_id);
      requeue_due = 1'b0;
    end
    if (!slot_open) begin
      q = (quantum == '0) ? 16'd1 : 16'(quantum);
      if (rr_line.size() != 0) begin
        cur_id     = rr_line.pop_front();
        slot_units = (units_left[cur_id] < q) ? units_left[cur_id] : q;
      end else if (fcfs_line.size() != 0) begin
        cur_id     = fcfs_line.pop_front();
        slot_units = units_left[cur_id];
      end else begin
        sched_now++;
        rep.idle = 1'b1;
        tick_reports = {tick_reports, rep};
        return;
      end
      slot_open      = 1'b1;
      rep.slot_start = 1'b1;
    end
    rep.running_id = cur_id;
    if (!started[cur_id]) begin
      first_start[cur_id] = sched_now;
      started[cur_id]     = 1'b1;
    end
    units_left[cur_id]--;
    slot_units--;
    sched_now++;
    if (units_left[cur_id] == '0) begin
      rep.finished        = 1'b1;
      rep.completion_time = sched_now;
      rep.turnaround      = sched_now - arrived_at[cur_id];
      rep.waiting         = rep.turnaround - 32'(burst_of[cur_id]);
      rep.response        = first_start[cur_id] - arrived_at[cur_id];
      busy[cur_id]        = 1'b0;
      slot_open           = 1'b0;
    end else if (slot_units == '0) begin
      slot_open   = 1'b0;
      requeue_due = 1'b1;
    end
    tick_reports = {tick_reports, rep};
  endtask

  // Offers one request and holds it until the block takes it. A random gap
  // may come first, during which in_valid is low.
  task automatic send_request(input logic act, input logic [IDP_W-1:0] id,
                              input logic lvl, input logic [BURST_W-1:0] burst);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_task_id      <= id;
    in_queue_level  <= lvl;
    in_burst_length <= burst;
    do @(posedge clk); while (!in_ready);
    schedule_request(act, id, lvl, burst);
  endtask

  // Finds a task id that is busy or free, starting at a random point.
  function automatic bit pick_task_id(input bit want_busy, output logic [IDP_W-1:0] id);
    int base;
    base = $urandom_range(0, NUM_TASKS - 1);
    for (int k = 0; k < NUM_TASKS; k++) begin
      id = IDP_W'((base + k) % NUM_TASKS);
      if (busy[id] == want_busy) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Stops offering requests and waits until every predicted result has been
  // taken, then lets the block finish any arrival still in flight.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (tick_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [QUANT_W-1:0] value);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    quantum  = value;
  endtask

  // Mostly well-formed traffic: arrivals of free ids with short bursts and a
  // majority of ticks. About one arrival in ten is noise that the block must
  // drop, either a zero burst or an id that is still active.
  task automatic run_phase(input int count);
    logic [IDP_W-1:0]   id;
    logic [BURST_W-1:0] burst;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) >= 28) begin
        send_request(ACT_TICK, IDP_W'($urandom), 1'($urandom), BURST_W'($urandom));
      end else if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 1 && pick_task_id(1'b1, id)) begin
          burst = BURST_W'($urandom_range(1, 65535));
        end else begin
          id    = IDP_W'($urandom);
          burst = '0;
        end
        send_request(ACT_ARRIVE, id, 1'($urandom), burst);
      end else if (pick_task_id(1'b0, id)) begin
        burst = ($urandom_range(0, 7) == 0) ? BURST_W'($urandom_range(7, 40))
                                            : BURST_W'($urandom_range(1, 6));
        send_request(ACT_ARRIVE, id, 1'($urandom), burst);
      end else begin
        send_request(ACT_TICK, IDP_W'($urandom), 1'($urandom), BURST_W'($urandom));
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_report();
    tick_report_t want;
    if (tick_reports.size() == 0) begin
      $display("%0t: result request with nothing expected, expected none, actual id %0h",
               $time, out_running_id);
      mismatch_count++;
      return;
    end
    want = tick_reports.pop_front();
    compare_field("idle",            32'(want.idle),       32'(out_idle));
    compare_field("running_id",      32'(want.running_id), 32'(out_running_id));
    compare_field("slot_start",      32'(want.slot_start), 32'(out_slot_start));
    compare_field("finished",        32'(want.finished),   32'(out_finished));
    compare_field("completion_time", want.completion_time, out_completion_time);
    compare_field("turnaround",      want.turnaround,      out_turnaround);
    compare_field("waiting",         want.waiting,         out_waiting);
    compare_field("response",        want.response,        out_response);
  endtask

  // Receiver: checks every accepted result against the oldest prediction and
  // decides out_ready for the next cycle. A long hold-off is counted here so
  // that the block fills its output register and then stalls its input.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_report();
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      stall_left   = HOLD_CYCLES - 1;
      out_ready   <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Main sequence: reset, directed table, random phases under several
  // quantum settings, a tail with the longest burst, then the verdict.
  initial begin
    logic [IDP_W-1:0] id;
    logic [QUANT_W-1:0] quanta [6];
    bit free_found;
    for (int k = 0; k < NUM_TASKS; k++) busy[k] = 1'b0;
    quanta = '{8'd1, 8'd0, 8'd255, 8'd3, QUANT_W'($urandom_range(4, 254)), 8'd2};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[r]) begin
      send_request(DIRECTED[r].act, DIRECTED[r].id, DIRECTED[r].lvl, DIRECTED[r].burst);
      if (DIRECTED[r].typed) tick_reports[tick_reports.size() - 1] = DIRECTED[r].want;
    end

    foreach (quanta[p]) begin
      write_quantum(quanta[p]);
      // The quantum of 255 phase also carries the long receiver hold-off.
      if (p == 2) hold_request = 1'b1;
      // The final phase and the tail run with both sides at full rate.
      if (p == 5) begin
        gaps_on      = 1'b0;
        rx_stalls_on = 1'b0;
      end
      run_phase(PHASE_ITEMS);
    end

    // A round-robin task with the largest burst; it cannot finish in the
    // remaining ticks, but it must take its turns with the others.
    free_found = pick_task_id(1'b0, id);
    if (free_found) begin
      send_request(ACT_ARRIVE, id, LVL_RR, 16'hFFFF);
    end
    repeat (10) send_request(ACT_TICK, '0, LVL_RR, '0);

    settle_block();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
